FILE: rtl/core/json_string_escape_decoder_defines.svh
// Assertion macros for the checker file of the escape decoder.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef JSON_STRING_ESCAPE_DECODER_DEFINES_SVH
`define JSON_STRING_ESCAPE_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define JSED_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsed assertion failed");

// Next-cycle implication, checked out of reset
`define JSED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsed assertion failed");

`endif

FILE: rtl/core/jsed_pkg.sv
// Shared types, character codes and decode functions of the escape decoder.
// Depends on nothing; used by every module of the block.
package jsed_pkg;

    // Result slots per decode pass
    localparam int unsigned MAX_RES = 4;

    // Character codes
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_QMARK  = 16'h003F;
    localparam logic [15:0] CH_ZERO   = 16'h0030;
    localparam logic [15:0] CH_NINE   = 16'h0039;
    localparam logic [15:0] CH_LC_A   = 16'h0061;
    localparam logic [15:0] CH_LC_F   = 16'h0066;
    localparam logic [15:0] CH_UC_A   = 16'h0041;
    localparam logic [15:0] CH_UC_F   = 16'h0046;

    // Escape letters
    localparam logic [15:0] ESC_B = 16'h0062;
    localparam logic [15:0] ESC_T = 16'h0074;
    localparam logic [15:0] ESC_N = 16'h006E;
    localparam logic [15:0] ESC_V = 16'h0076;
    localparam logic [15:0] ESC_F = 16'h0066;
    localparam logic [15:0] ESC_R = 16'h0072;
    localparam logic [15:0] ESC_X = 16'h0078;
    localparam logic [15:0] ESC_U = 16'h0075;

    // Control characters the escapes map to
    localparam logic [15:0] CTRL_BS = 16'h0008;
    localparam logic [15:0] CTRL_HT = 16'h0009;
    localparam logic [15:0] CTRL_LF = 16'h000A;
    localparam logic [15:0] CTRL_VT = 16'h000B;
    localparam logic [15:0] CTRL_FF = 16'h000C;
    localparam logic [15:0] CTRL_CR = 16'h000D;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_HEX2 = 2'd1,
        ERR_HEX4 = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX2 = 2'd2,
        MODE_HEX4 = 2'd3
    } mode_t;

    // One result item
    typedef struct packed {
        logic [15:0] ch;
        logic        has;
        err_t        err;
    } res_t;

    // Scanner state
    typedef struct packed {
        mode_t            mode;
        logic [1:0]       cnt;
        logic [2:0][15:0] dig;
    } scan_t;

    // Results gathered in one pass
    typedef struct packed {
        logic [2:0]   n;
        res_t [3:0]   r;
    } acc_t;

    typedef struct packed {
        scan_t s;
        acc_t  a;
    } dec_t;

    // Hex digit value: {bad, value}
    function automatic logic [4:0] hexval(logic [15:0] c);
        logic is_dec;
        logic is_alpha;
        is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
        is_alpha = ((c >= CH_LC_A) && (c <= CH_LC_F)) || ((c >= CH_UC_A) && (c <= CH_UC_F));
        if (is_dec)
            return {1'b0, c[3:0]};
        else if (is_alpha)
            return {1'b0, c[3:0] + 4'd9};
        else
            return {1'b1, 4'd0};
    endfunction

    // Append one result, dropping anything past the last slot
    function automatic acc_t put_fn(acc_t a, logic [15:0] ch, logic has, err_t err);
        acc_t o;
        o = a;
        if (o.n < 3'(MAX_RES)) begin
            o.r[o.n[1:0]] = '{ch: (has ? ch : 16'h0000), has: has, err: err};
            o.n           = o.n + 3'd1;
        end
        return o;
    endfunction

    // Character handled as ordinary text
    function automatic dec_t plain_fn(dec_t d, logic [15:0] c);
        dec_t o;
        o = d;
        if (c == CH_BSLASH)
            o.s.mode = MODE_ESC;
        else
            o.a = put_fn(o.a, c, 1'b1, ERR_NONE);
        return o;
    endfunction

    // One character through the scanner
    function automatic dec_t feed_fn(dec_t d, logic [15:0] c);
        dec_t        o;
        logic        hex4;
        logic [4:0]  h0;
        logic [4:0]  h1;
        logic [4:0]  h2;
        logic [4:0]  hc;
        logic        bad;
        logic [15:0] v;
        err_t        err;
        o    = d;
        hex4 = (d.s.mode == MODE_HEX4);
        h0   = hexval(d.s.dig[0]);
        h1   = hexval(d.s.dig[1]);
        h2   = hexval(d.s.dig[2]);
        hc   = hexval(c);
        if (hex4) begin
            bad = h0[4] | h1[4] | h2[4] | hc[4];
            v   = {h0[3:0], h1[3:0], h2[3:0], hc[3:0]};
            err = ERR_HEX4;
        end
        else begin
            bad = h0[4] | hc[4];
            v   = {8'h00, h0[3:0], hc[3:0]};
            err = ERR_HEX2;
        end
        unique case (d.s.mode) inside
            MODE_TEXT:
            begin
                o = plain_fn(o, c);
            end
            MODE_ESC:
            begin
                o.s.mode = MODE_TEXT;
                unique case (c)
                    CH_BSLASH: o.a = put_fn(o.a, CH_BSLASH, 1'b1, ERR_NONE);
                    CH_SLASH:  o.a = put_fn(o.a, CH_SLASH, 1'b1, ERR_NONE);
                    CH_QUOTE:  o.a = put_fn(o.a, CH_QUOTE, 1'b1, ERR_NONE);
                    ESC_B:     o.a = put_fn(o.a, CTRL_BS, 1'b1, ERR_NONE);
                    ESC_T:     o.a = put_fn(o.a, CTRL_HT, 1'b1, ERR_NONE);
                    ESC_N:     o.a = put_fn(o.a, CTRL_LF, 1'b1, ERR_NONE);
                    ESC_V:     o.a = put_fn(o.a, CTRL_VT, 1'b1, ERR_NONE);
                    ESC_F:     o.a = put_fn(o.a, CTRL_FF, 1'b1, ERR_NONE);
                    ESC_R:     o.a = put_fn(o.a, CTRL_CR, 1'b1, ERR_NONE);
                    ESC_X:
                    begin
                        o.s.mode = MODE_HEX2;
                        o.s.cnt  = 2'd0;
                    end
                    ESC_U:
                    begin
                        o.s.mode = MODE_HEX4;
                        o.s.cnt  = 2'd0;
                    end
                    default:
                    begin
                        // unknown escape: emit the backslash, rescan the character
                        o.a = put_fn(o.a, CH_BSLASH, 1'b1, ERR_NONE);
                        o   = plain_fn(o, c);
                    end
                endcase
            end
            MODE_HEX2, MODE_HEX4:
            begin
                if ((hex4 && (d.s.cnt != 2'd3)) || (!hex4 && (d.s.cnt == 2'd0))) begin
                    // still gathering digits
                    case (d.s.cnt)
                        2'd0:    o.s.dig[0] = c;
                        2'd1:    o.s.dig[1] = c;
                        default: o.s.dig[2] = c;
                    endcase
                    o.s.cnt = d.s.cnt + 2'd1;
                end
                else begin
                    if (bad)
                        o.a = put_fn(o.a, CH_QMARK, 1'b1, err);
                    else
                        o.a = put_fn(o.a, v, 1'b1, ERR_NONE);
                    o.s.mode = MODE_TEXT;
                    o.s.cnt  = 2'd0;
                end
            end
        endcase
        return o;
    endfunction

endpackage

FILE: rtl/core/jsed_step.sv
// Decode pass of the escape decoder: one character, or one end-of-string pass.
// Depends on jsed_pkg.
module jsed_step
(
    input  logic            finishing,
    input  jsed_pkg::scan_t state,
    input  logic [15:0]     character,
    output jsed_pkg::dec_t  result
);

    jsed_pkg::dec_t d;

    // End pass: flush a pending backslash, or flag a short hex escape and rescan its digits
    always_comb
    begin
        d.s = state;
        d.a = '0;
        if (finishing) begin
            case (state.mode) inside
                jsed_pkg::MODE_ESC:
                begin
                    d.a      = jsed_pkg::put_fn(d.a, jsed_pkg::CH_BSLASH, 1'b1,
                                                jsed_pkg::ERR_NONE);
                    d.s.mode = jsed_pkg::MODE_TEXT;
                end
                jsed_pkg::MODE_HEX2, jsed_pkg::MODE_HEX4:
                begin
                    d.a      = jsed_pkg::put_fn(d.a, 16'h0000, 1'b0,
                                   (state.mode == jsed_pkg::MODE_HEX2) ?
                                   jsed_pkg::ERR_HEX2 : jsed_pkg::ERR_HEX4);
                    d.s.mode = jsed_pkg::MODE_TEXT;
                    d.s.cnt  = 2'd0;
                    for (int i = 0; i < 3; i++) begin
                        if (i < int'(state.cnt))
                            d = jsed_pkg::feed_fn(d, state.dig[i]);
                    end
                end
                default:
                begin
                    d.s.mode = jsed_pkg::MODE_TEXT;
                end
            endcase
        end
        else begin
            d = jsed_pkg::feed_fn(d, character);
        end
    end

    assign result = d;

endmodule

FILE: rtl/core/jsed_out_buf.sv
// Result register of the escape decoder: holds the results of one pass and
// hands them out one transfer per cycle while m_tready is high. Depends on jsed_pkg.
module jsed_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  jsed_pkg::acc_t      load_acc,
    input  logic                load_eos,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,    // out_character
    output logic [2:0]          m_tuser,    // has_character, error_code[1:0]
    output logic                m_tlast     // end_of_string
);

    logic [2:0]           n_reg;
    logic [2:0]           n_next;
    logic [1:0]           idx_reg;
    logic [1:0]           idx_next;
    logic                 eos_reg;
    logic                 eos_next;
    jsed_pkg::res_t [3:0] res_reg;
    jsed_pkg::res_t [3:0] res_next;
    jsed_pkg::res_t       cur;
    logic                 pop;
    logic                 last_one;

    // Output side
    assign cur      = res_reg[idx_reg];
    assign m_tvalid = (n_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign last_one = (({1'b0, idx_reg} + 3'd1) == n_reg);
    assign free     = !m_tvalid || (pop && last_one);
    assign m_tdata  = cur.ch;
    assign m_tuser  = {cur.err, cur.has};
    assign m_tlast  = eos_reg && last_one;

    // Load a new set or step through the current one
    always_comb
    begin
        n_next   = n_reg;
        idx_next = idx_reg;
        eos_next = eos_reg;
        res_next = res_reg;
        if (load) begin
            n_next   = load_acc.n;
            idx_next = 2'd0;
            eos_next = load_eos;
            res_next = load_acc.r;
        end
        else if (pop) begin
            if (last_one)
                n_next = 3'd0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            n_reg   <= 3'd0;
            idx_reg <= 2'd0;
            eos_reg <= 1'b0;
        end
        else begin
            n_reg   <= n_next;
            idx_reg <= idx_next;
            eos_reg <= eos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

FILE: rtl/core/json_string_escape_decoder.sv
// Escape decoder for the body of one string, one UTF-16 code unit a transfer.
// Depends on jsed_pkg, jsed_step and jsed_out_buf.
//
// The block takes one character per cycle and gives one result per cycle
// while m_tready is high and no pass waits on the result register. A
// character goes into an input register, is decoded in one pass against the
// scanner state, and its results (none to two) go into the result register,
// which hands them out one transfer per cycle. An unknown escape yields two
// results; a later pass with results waits until both have gone out. When a
// string ends inside an escape, one more pass per pending escape runs (a
// backslash, or an error plus the rescanned digits, up to four results),
// each waiting until the result register has handed out the last set.
module json_string_escape_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // character
    input  logic        s_tlast,    // last_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // out_character
    output logic [2:0]  m_tuser,    // has_character, error_code[1:0]
    output logic        m_tlast     // end_of_string
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [15:0]          char_reg;
    logic                 last_reg;
    logic                 finishing_reg;
    logic                 finishing_next;
    jsed_pkg::mode_t      mode_reg;
    jsed_pkg::mode_t      mode_next;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    logic [2:0][15:0]     dig_reg;
    logic [2:0][15:0]     dig_next;
    jsed_pkg::scan_t      state;
    jsed_pkg::dec_t       dec;
    logic                 buf_free;
    logic                 active;
    logic                 advance;
    logic                 consume;
    logic                 ends;
    logic                 done_mode;
    logic                 s_fire;

    assign state = '{mode: mode_reg, cnt: cnt_reg, dig: dig_reg};

    jsed_step u_step
    (
        .finishing (finishing_reg),
        .state     (state),
        .character (char_reg),
        .result    (dec)
    );

    // Pass control: a pass completes once its results fit in the result register
    assign active    = finishing_reg || in_valid_reg;
    assign advance   = active && ((dec.a.n == 3'd0) || buf_free);
    assign consume   = advance && !finishing_reg;
    assign ends      = finishing_reg || last_reg;
    assign done_mode = (dec.s.mode == jsed_pkg::MODE_TEXT);
    assign s_tready  = !in_valid_reg || consume;
    assign s_fire    = s_tvalid && s_tready;

    jsed_out_buf u_out_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && (dec.a.n != 3'd0)),
        .load_acc (dec.a),
        .load_eos (ends && done_mode),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Next state of the scanner and the input stage
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        finishing_next = finishing_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        dig_next       = dig_reg;
        if (consume)
            in_valid_next = 1'b0;
        if (s_fire)
            in_valid_next = 1'b1;
        if (advance) begin
            mode_next      = dec.s.mode;
            cnt_next       = (ends && done_mode) ? 2'd0 : dec.s.cnt;
            dig_next       = dec.s.dig;
            finishing_next = ends && !done_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            finishing_reg <= 1'b0;
            mode_reg      <= jsed_pkg::MODE_TEXT;
            cnt_reg       <= 2'd0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            finishing_reg <= finishing_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        if (s_fire) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule

FILE: rtl/core/jsed_checker.sv
// Port-level checks of the escape decoder, bound to the top level.
// Depends on jsed_pkg and json_string_escape_decoder_defines.svh.
`include "json_string_escape_decoder_defines.svh"

module jsed_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Stalled result transfer keeps its payload
    `JSED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // A result without a character is a short escape: zero data and an error code
    `JSED_ASSERT_NOW(a_nochar_err, m_tvalid && !m_tuser[0], (m_tdata == 16'h0000) && (m_tuser[2:1] != 2'(jsed_pkg::ERR_NONE)))

    // Error code stays within the defined codes
    `JSED_ASSERT_NOW(a_err_range, m_tvalid, (m_tuser[2:1] == 2'(jsed_pkg::ERR_NONE)) || (m_tuser[2:1] == 2'(jsed_pkg::ERR_HEX2)) || (m_tuser[2:1] == 2'(jsed_pkg::ERR_HEX4)))

    // A bad-digit error carries the replacement mark
    `JSED_ASSERT_NOW(a_bad_qmark, m_tvalid && m_tuser[0] && (m_tuser[2:1] != 2'(jsed_pkg::ERR_NONE)), m_tdata == jsed_pkg::CH_QMARK)

endmodule

bind json_string_escape_decoder jsed_checker u_jsed_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for json_string_escape_decoder: strings of UTF-16 code
// units go in as stream transfers, and decoded results are checked against a predictor.
// Depends on jsed_pkg for the mode and error codes and for the character constants.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 400;

    // One character waiting to be sent; hold makes the sender wait for a full drain
    typedef struct {
        logic [15:0] ch;
        logic        last;
        logic        hold;
    } char_item_t;

    // One decoded result as the block should produce it
    typedef struct {
        logic [15:0]    ch;
        logic           has;
        jsed_pkg::err_t err;
        logic           eos;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    char_item_t  send_q [$];
    decoded_t    decoded_q [$];
    decoded_t    step_out [$];

    // Predictor state
    jsed_pkg::mode_t scan_state;
    int              digit_cnt;
    logic [15:0]     digit_buf [3];

    int          n_predicted = 0;
    int          n_checked = 0;
    int          error_count = 0;
    int          strings_done = 0;
    int          error_results = 0;
    int          rand_items = 0;
    int          cycle_cnt = 0;

    // Sender pacing
    int          burst_left = 4;
    int          gap_left = 0;
    logic        xfer_in;
    logic        drained;

    // Receiver stall pattern
    logic [15:0] stall_pat = 16'hFFFF;
    int          stall_pos = 0;

    json_string_escape_decoder u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic flag_error(string msg);
        $display("tb_top: ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------- predictor ----------------

    function automatic int hex_nibble(logic [15:0] c);
        if (c >= jsed_pkg::CH_ZERO && c <= jsed_pkg::CH_NINE)
            return int'(c - jsed_pkg::CH_ZERO);
        if (c >= jsed_pkg::CH_LC_A && c <= jsed_pkg::CH_LC_F)
            return int'(c - jsed_pkg::CH_LC_A) + 10;
        if (c >= jsed_pkg::CH_UC_A && c <= jsed_pkg::CH_UC_F)
            return int'(c - jsed_pkg::CH_UC_A) + 10;
        return -1;
    endfunction

    // Results past the fourth of one step are dropped
    function automatic void push_result(logic [15:0] ch, logic has, jsed_pkg::err_t err);
        decoded_t r;
        if (step_out.size() < jsed_pkg::MAX_RES)
        begin
            r.ch  = has ? ch : 16'h0000;
            r.has = has;
            r.err = err;
            r.eos = 1'b0;
            step_out.insert(step_out.size(), r);
        end
    endfunction

    function automatic void scan_plain(logic [15:0] c);
        if (c == jsed_pkg::CH_BSLASH)
            scan_state = jsed_pkg::MODE_ESC;
        else
            push_result(c, 1'b1, jsed_pkg::ERR_NONE);
    endfunction

    function automatic void scan_char(logic [15:0] c);
        int             need;
        int             d;
        logic           bad;
        logic [15:0]    acc;
        jsed_pkg::err_t code;
        case (scan_state)
            jsed_pkg::MODE_TEXT:
            begin
                scan_plain(c);
            end
            jsed_pkg::MODE_ESC:
            begin
                scan_state = jsed_pkg::MODE_TEXT;
                case (c)
                    jsed_pkg::CH_BSLASH:
                        push_result(jsed_pkg::CH_BSLASH, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::CH_SLASH:
                        push_result(jsed_pkg::CH_SLASH, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::CH_QUOTE:
                        push_result(jsed_pkg::CH_QUOTE, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::ESC_B:
                        push_result(jsed_pkg::CTRL_BS, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::ESC_T:
                        push_result(jsed_pkg::CTRL_HT, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::ESC_N:
                        push_result(jsed_pkg::CTRL_LF, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::ESC_V:
                        push_result(jsed_pkg::CTRL_VT, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::ESC_F:
                        push_result(jsed_pkg::CTRL_FF, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::ESC_R:
                        push_result(jsed_pkg::CTRL_CR, 1'b1, jsed_pkg::ERR_NONE);
                    jsed_pkg::ESC_X:
                    begin
                        scan_state = jsed_pkg::MODE_HEX2;
                        digit_cnt  = 0;
                    end
                    jsed_pkg::ESC_U:
                    begin
                        scan_state = jsed_pkg::MODE_HEX4;
                        digit_cnt  = 0;
                    end
                    default:
                    begin
                        // unknown escape: backslash out, character rescanned as text
                        push_result(jsed_pkg::CH_BSLASH, 1'b1, jsed_pkg::ERR_NONE);
                        scan_plain(c);
                    end
                endcase
            end
            default:
            begin
                if (scan_state == jsed_pkg::MODE_HEX2)
                begin
                    need = 2;
                    code = jsed_pkg::ERR_HEX2;
                end
                else
                begin
                    need = 4;
                    code = jsed_pkg::ERR_HEX4;
                end
                if (digit_cnt + 1 < need)
                begin
                    digit_buf[digit_cnt] = c;
                    digit_cnt++;
                end
                else
                begin
                    acc = 16'h0000;
                    bad = 1'b0;
                    for (int i = 0; i < need - 1; i++)
                    begin
                        d = hex_nibble(digit_buf[i]);
                        if (d < 0)
                            bad = 1'b1;
                        else
                            acc = {acc[11:0], 4'(d)};
                    end
                    d = hex_nibble(c);
                    if (d < 0)
                        bad = 1'b1;
                    else
                        acc = {acc[11:0], 4'(d)};
                    if (bad)
                        push_result(jsed_pkg::CH_QMARK, 1'b1, code);
                    else
                        push_result(acc, 1'b1, jsed_pkg::ERR_NONE);
                    scan_state = jsed_pkg::MODE_TEXT;
                    digit_cnt  = 0;
                end
            end
        endcase
    endfunction

    // String end: flush open escapes, rescanning gathered digits as text
    function automatic void close_string();
        logic [15:0] held [3];
        int          n;
        for (int g = 0; g < 8; g++)
        begin
            if (scan_state == jsed_pkg::MODE_ESC)
            begin
                push_result(jsed_pkg::CH_BSLASH, 1'b1, jsed_pkg::ERR_NONE);
                scan_state = jsed_pkg::MODE_TEXT;
            end
            else if (scan_state == jsed_pkg::MODE_HEX2 || scan_state == jsed_pkg::MODE_HEX4)
            begin
                if (scan_state == jsed_pkg::MODE_HEX2)
                    push_result(16'h0000, 1'b0, jsed_pkg::ERR_HEX2);
                else
                    push_result(16'h0000, 1'b0, jsed_pkg::ERR_HEX4);
                n = digit_cnt;
                for (int i = 0; i < n; i++)
                    held[i] = digit_buf[i];
                scan_state = jsed_pkg::MODE_TEXT;
                digit_cnt  = 0;
                for (int i = 0; i < n; i++)
                    scan_char(held[i]);
            end
            else
            begin
                break;
            end
        end
        scan_state = jsed_pkg::MODE_TEXT;
        digit_cnt  = 0;
    endfunction

    function automatic void predict_item(logic [15:0] c, logic last);
        step_out.delete();
        scan_char(c);
        if (last)
        begin
            close_string();
            strings_done++;
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].eos = 1'b1;
        end
        foreach (step_out[i])
        begin
            if (step_out[i].err != jsed_pkg::ERR_NONE)
                error_results++;
            decoded_q.insert(decoded_q.size(), step_out[i]);
        end
        n_predicted += step_out.size();
    endfunction

    // ---------------- stimulus ----------------

    task automatic queue_char(logic [15:0] ch, logic last, logic hold);
        char_item_t item;
        item.ch   = ch;
        item.last = last;
        item.hold = hold;
        send_q.insert(send_q.size(), item);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(16'(s[i]), (i == s.len() - 1), 1'b0);
    endtask

    // Mostly hex digits, sometimes a near miss or a backslash
    function automatic logic [15:0] pick_digit();
        string hexset = "0123456789abcdefABCDEF";
        string badset = "/:@G`g \\";
        if ($urandom_range(0, 9) != 0)
            return 16'(hexset[$urandom_range(0, 21)]);
        return 16'(badset[$urandom_range(0, badset.len() - 1)]);
    endfunction

    // One string of random tokens, sometimes cut short, which can end it inside an escape
    task automatic add_random_string();
        logic [15:0] body [$];
        int          tokens;
        int          kind;
        int          cut;
        logic        hold;
        logic [15:0] c;
        tokens = $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                c = 16'($urandom_range(32, 126));
                body.insert(body.size(), (c == jsed_pkg::CH_BSLASH) ? jsed_pkg::CH_QUOTE : c);
            end
            else if (kind < 45)
            begin
                body.insert(body.size(), jsed_pkg::CH_BSLASH);
                case ($urandom_range(0, 8))
                    0:       body.insert(body.size(), jsed_pkg::CH_BSLASH);
                    1:       body.insert(body.size(), jsed_pkg::CH_SLASH);
                    2:       body.insert(body.size(), jsed_pkg::CH_QUOTE);
                    3:       body.insert(body.size(), jsed_pkg::ESC_B);
                    4:       body.insert(body.size(), jsed_pkg::ESC_T);
                    5:       body.insert(body.size(), jsed_pkg::ESC_N);
                    6:       body.insert(body.size(), jsed_pkg::ESC_V);
                    7:       body.insert(body.size(), jsed_pkg::ESC_F);
                    default: body.insert(body.size(), jsed_pkg::ESC_R);
                endcase
            end
            else if (kind < 60)
            begin
                body.insert(body.size(), jsed_pkg::CH_BSLASH);
                body.insert(body.size(), jsed_pkg::ESC_X);
                repeat (2) body.insert(body.size(), pick_digit());
            end
            else if (kind < 75)
            begin
                body.insert(body.size(), jsed_pkg::CH_BSLASH);
                body.insert(body.size(), jsed_pkg::ESC_U);
                repeat (4) body.insert(body.size(), pick_digit());
            end
            else if (kind < 85)
            begin
                body.insert(body.size(), jsed_pkg::CH_BSLASH);
                body.insert(body.size(), 16'($urandom));
            end
            else
            begin
                body.insert(body.size(), 16'($urandom));
            end
        end
        if ($urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(1, body.size());
            while (body.size() > cut)
                void'(body.pop_back());
        end
        hold = ($urandom_range(0, 19) == 0);
        foreach (body[i])
            queue_char(body[i], (i == body.size() - 1), hold && (i == 0));
        rand_items += body.size();
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'h0000;
            s_tlast  <= 1'b0;
        end
        else
        begin
            xfer_in = s_tvalid && s_tready;
            if (xfer_in)
                predict_item(s_tdata, s_tlast);
            // all results in by the end of this edge
            drained = (n_predicted == n_checked + ((m_tvalid && m_tready) ? 1 : 0));
            if (!s_tvalid || xfer_in)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (send_q.size() == 0 || (send_q[0].hold && !drained))
                begin
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= send_q[0].ch;
                    s_tlast  <= send_q[0].last;
                    void'(send_q.pop_front());
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= stall_pat[stall_pos];
            if (stall_pos == 15)
            begin
                stall_pos = 0;
                case ($urandom_range(0, 7))
                    0, 1:    stall_pat = 16'hFFFF;
                    2:       stall_pat = 16'($urandom) & 16'($urandom) | 16'h0001;
                    default: stall_pat = 16'($urandom) | 16'h0100;
                endcase
            end
            else
            begin
                stall_pos++;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                flag_error($sformatf("unexpected result ch=%h user=%b last=%b",
                                     m_tdata, m_tuser, m_tlast));
            end
            else
            begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.ch || m_tuser[0] !== want.has ||
                    m_tuser[2:1] !== want.err || m_tlast !== want.eos)
                    flag_error($sformatf(
                        "result %0d: got %h/%b/%0d/%b, want %h/%b/%0d/%b",
                        n_checked, m_tdata, m_tuser[0], m_tuser[2:1], m_tlast,
                        want.ch, want.has, want.err, want.eos));
            end
            n_checked <= n_checked + 1;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        int first_rand;
        scan_state = jsed_pkg::MODE_TEXT;
        digit_cnt  = 0;

        // extremes of the code unit range
        queue_char(16'h0000, 1'b0, 1'b0);
        queue_char(16'hFFFF, 1'b1, 1'b0);
        push_text("\\x7F");      // two-digit escape
        push_text("\\u12G4");    // bad digit in a four-digit escape
        push_text("\\uA\\q");    // short escape, rescan gives four results
        push_text("z\\");        // lone backslash at the end
        push_text("\\q\\n");     // unknown escape followed by a real one
        push_text("\\x");        // short two-digit escape

        first_rand = send_q.size();
        while (rand_items < RANDOM_ITEMS)
            add_random_string();
        send_q[first_rand].hold = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (send_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (n_checked != n_predicted)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (decoded_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", decoded_q.size()));

        $display("tb_top: %0d strings (%0d random characters) decoded, %0d results checked",
                 strings_done, rand_items, n_checked);
        $display("tb_top: %0d results carried error codes, %0d mismatches",
                 error_results, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_top: timeout after %0d cycles", cycle_cnt);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
